### sv/rle_rgb565_frame_rasterizer_unit_macros.svh
// ----------------------------------------------------------------------------
// rle rgb565 frame rasterizer assertion macros
// Shared concurrent assertion forms for the rasterizer checks.
// ----------------------------------------------------------------------------
`ifndef RLE_RGB565_FRAME_RASTERIZER_UNIT_MACROS_SVH
`define RLE_RGB565_FRAME_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define RRFR_ASSERT_IMPLY(name, clock, reset, cond, expr) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("rrfr same-cycle check failed");

// next-cycle implication, off during reset
`define RRFR_ASSERT_NEXT(name, clock, reset, cond, expr) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("rrfr next-cycle check failed");

`endif

### sv/rrfr_pkg.sv
// ----------------------------------------------------------------------------
// rrfr_pkg
// Types, constants and helpers shared by the run-length frame rasterizer.
// ----------------------------------------------------------------------------
package rrfr_pkg;

  localparam int MAX_DIM    = 2048;
  localparam int CFG_W      = 12;
  localparam int DIM_W      = CFG_W;
  localparam int COUNT_W    = 16;
  localparam int COLOR_IN_W = 16;
  localparam int COLOR_W    = 24;
  localparam int POS_W      = 11;
  localparam int TOTAL_W    = 2 * DIM_W - 1;
  localparam int GEO_W      = COUNT_W + 2;
  localparam int DIV_STEPS  = COUNT_W;
  localparam int FQ_DEPTH   = 2;
  localparam int OQ_DEPTH   = 4;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

  localparam logic [4:0] RB_MASK = 5'h1f;
  localparam logic [5:0] G_MASK  = 6'h3f;

  typedef struct packed {
    logic [CFG_W-1:0]        frame_width;
    logic [CFG_W-1:0]        frame_height;
    logic signed [CFG_W-1:0] origin_x;
    logic signed [CFG_W-1:0] origin_y;
    logic [CFG_W-1:0]        screen_width;
    logic [CFG_W-1:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COLOR_W-1:0] color;
    logic               zero_run;
    logic               frame_start;
    logic               last_of_frame;
  } run_t;

  typedef struct packed {
    logic [POS_W-1:0]   fill_x;
    logic [POS_W-1:0]   fill_y;
    logic [DIM_W-1:0]   fill_w;
    logic [DIM_W-1:0]   fill_h;
    logic [COLOR_W-1:0] color;
    logic               fill_valid;
    logic               last;
    logic               frame_complete;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_CLAMP,
    ST_HEAD,
    ST_MID_CHECK,
    ST_DIV_WAIT,
    ST_TAIL,
    ST_GEOM,
    ST_PUSH
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    return (v > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

  function automatic logic [COLOR_W-1:0] widen_color(input logic [COLOR_IN_W-1:0] c);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11] & RB_MASK;
    g = c[10:5] & G_MASK;
    b = c[4:0] & RB_MASK;
    return {r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

endpackage

### sv/rle_rgb565_frame_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// rle_rgb565_frame_rasterizer_unit
// Run-length RGB565 decoder that turns runs into clipped fill rectangles.
// ----------------------------------------------------------------------------
// channel  dir  handshake       word
// run      in   push / full     run_count run_color frame_start last_of_frame
// fill     out  pop / empty     fill_x fill_y fill_w fill_h fill_color
//                               fill_valid last frame_complete
// config   in   wr_en           wr_index wr_data
//
// a skipped run passes the idle, class and push states of the back end; a run
// with a partial first row, whole rows and a partial last row also waits on
// the bit-per-cycle row divider. a two-word input queue and a four-word result
// queue let push and pop stall independently. reset is synchronous and clears
// the position, pixel count, queues and registers to their defaults.
// ----------------------------------------------------------------------------
`include "rle_rgb565_frame_rasterizer_unit_macros.svh"

module rle_rgb565_frame_rasterizer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [rrfr_pkg::COUNT_W-1:0]      run_count,
  input  logic [rrfr_pkg::COLOR_IN_W-1:0]   run_color,
  input  logic                              frame_start,
  input  logic                              last_of_frame,
  output logic                              empty,
  input  logic                              pop,
  output logic [rrfr_pkg::POS_W-1:0]        fill_x,
  output logic [rrfr_pkg::POS_W-1:0]        fill_y,
  output logic [rrfr_pkg::DIM_W-1:0]        fill_w,
  output logic [rrfr_pkg::DIM_W-1:0]        fill_h,
  output logic [rrfr_pkg::COLOR_W-1:0]      fill_color,
  output logic                              fill_valid,
  output logic                              last,
  output logic                              frame_complete,
  input  logic                              wr_en,
  input  logic [rrfr_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [rrfr_pkg::CFG_W-1:0]        wr_data
);
  import rrfr_pkg::*;

  cfg_t               cfg;
  run_t               run_head;
  logic               run_empty;
  logic               run_pop;
  result_t            res;
  logic               res_push;
  logic               res_full;
  result_t            out_head;
  logic               div_start;
  logic [COUNT_W-1:0] dividend;
  logic [DIM_W-1:0]   divisor;
  logic [COUNT_W-1:0] quotient;
  logic [DIM_W-1:0]   remainder;
  div_status_t        div_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= CFG_W'(1);
      cfg.frame_height  <= CFG_W'(1);
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.screen_width  <= CFG_W'(1);
      cfg.screen_height <= CFG_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_WIDTH:   cfg.frame_width   <= wr_data;
        REG_FRAME_HEIGHT:  cfg.frame_height  <= wr_data;
        REG_ORIGIN_X:      cfg.origin_x      <= wr_data;
        REG_ORIGIN_Y:      cfg.origin_y      <= wr_data;
        REG_SCREEN_WIDTH:  cfg.screen_width  <= wr_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= wr_data;
        default: ;
      endcase
    end
  end

  rrfr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .run_count     (run_count),
    .run_color     (run_color),
    .frame_start   (frame_start),
    .last_of_frame (last_of_frame),
    .pop           (run_pop),
    .q_empty       (run_empty),
    .head          (run_head)
  );

  rrfr_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (div_status)
  );

  rrfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .run        (run_head),
    .run_empty  (run_empty),
    .run_pop    (run_pop),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full),
    .div_start  (div_start),
    .dividend   (dividend),
    .divisor    (divisor),
    .quotient   (quotient),
    .remainder  (remainder),
    .div_status (div_status)
  );

  rrfr_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .data  (res),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .head  (out_head)
  );

  assign fill_x         = out_head.fill_x;
  assign fill_y         = out_head.fill_y;
  assign fill_w         = out_head.fill_w;
  assign fill_h         = out_head.fill_h;
  assign fill_color     = out_head.color;
  assign fill_valid     = out_head.fill_valid;
  assign last           = out_head.last;
  assign frame_complete = out_head.frame_complete;

  `RRFR_ASSERT_IMPLY(a_no_res_overflow, clk, rst, res_push, !res_full)
  `RRFR_ASSERT_IMPLY(a_complete_on_last, clk, rst, (!empty && frame_complete), last)
  `RRFR_ASSERT_IMPLY(a_hidden_is_zero, clk, rst, (!empty && !fill_valid),
                     (fill_w == '0 && fill_h == '0 && fill_color == '0))
  `RRFR_ASSERT_NEXT(a_div_runs, clk, rst, div_start, div_status.busy)

endmodule

### sv/rrfr_front.sv
// ----------------------------------------------------------------------------
// rrfr_front
// Accepts run words, widens the colour, flags zero runs and queues them.
// ----------------------------------------------------------------------------
module rrfr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rrfr_pkg::COUNT_W-1:0]  run_count,
  input  logic [rrfr_pkg::COLOR_IN_W-1:0] run_color,
  input  logic                          frame_start,
  input  logic                          last_of_frame,
  input  logic                          pop,
  output logic                          q_empty,
  output rrfr_pkg::run_t                head
);
  import rrfr_pkg::*;

  localparam int PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(FQ_DEPTH + 1);

  run_t             slots [FQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;
  run_t             item;

  assign full    = (fill == CNT_W'(FQ_DEPTH));
  assign q_empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !q_empty;
  assign head    = slots[rd_ptr];

  always_comb begin
    item.count         = run_count;
    item.color         = widen_color(run_color);
    item.zero_run      = (run_count == '0);
    item.frame_start   = frame_start;
    item.last_of_frame = last_of_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item;
    end
  end

endmodule

### sv/rrfr_divider.sv
// ----------------------------------------------------------------------------
// rrfr_divider
// Restoring divider, one quotient bit per cycle, for the whole-row split.
// ----------------------------------------------------------------------------
module rrfr_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rrfr_pkg::COUNT_W-1:0] dividend,
  input  logic [rrfr_pkg::DIM_W-1:0]   divisor,
  output logic [rrfr_pkg::COUNT_W-1:0] quotient,
  output logic [rrfr_pkg::DIM_W-1:0]   remainder,
  output rrfr_pkg::div_status_t        status
);
  import rrfr_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [COUNT_W-1:0] quo;
  logic [DIM_W-1:0]   rem;
  logic [DIM_W:0]     trial;
  logic [DIM_W:0]     diff;
  logic               ge;

  // remainder stays below the divisor, so the shifted trial fits one extra bit
  assign trial = {rem, quo[COUNT_W-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      quo <= {quo[COUNT_W-2:0], ge};
    end
  end

endmodule

### sv/rrfr_back.sv
// ----------------------------------------------------------------------------
// rrfr_back
// Lays each queued run on the raster and emits up to three clipped rectangles.
// ----------------------------------------------------------------------------
module rrfr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  rrfr_pkg::cfg_t               cfg,
  input  rrfr_pkg::run_t               run,
  input  logic                         run_empty,
  output logic                         run_pop,
  output rrfr_pkg::result_t            res,
  output logic                         res_push,
  input  logic                         res_full,
  output logic                         div_start,
  output logic [rrfr_pkg::COUNT_W-1:0] dividend,
  output logic [rrfr_pkg::DIM_W-1:0]   divisor,
  input  logic [rrfr_pkg::COUNT_W-1:0] quotient,
  input  logic [rrfr_pkg::DIM_W-1:0]   remainder,
  input  rrfr_pkg::div_status_t        div_status
);
  import rrfr_pkg::*;

  back_state_t state;
  back_state_t state_next;
  back_state_t ret_state;

  // raster state
  logic [TOTAL_W-1:0] pd;
  logic [DIM_W-1:0]   col;
  logic [DIM_W-1:0]   row;

  // current run
  logic [COUNT_W-1:0] count_r;
  logic [COLOR_W-1:0] color_r;
  logic               zero_r;
  logic               lof_r;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] rem_px;
  logic [COUNT_W-1:0] left;
  logic               comp;
  logic               null_res;

  // current rectangle
  logic [DIM_W-1:0]   rect_col;
  logic [DIM_W-1:0]   rect_row;
  logic [COUNT_W-1:0] rect_w;
  logic [DIM_W-1:0]   rect_h;
  logic               rect_last;
  logic signed [GEO_W-1:0] gx0, gx1, gy0, gy1;

  logic [DIM_W-1:0]   fw, fh, sw, sh;
  logic [2*DIM_W-1:0] prod;
  logic [DIM_W-1:0]   head_room;
  logic               head_over;
  logic               head_fit;
  logic               head_wrap;
  logic [COUNT_W-1:0] head_a;
  logic [DIM_W-1:0]   head_col_sum;
  logic [COUNT_W-1:0] cnt_clamp;
  logic signed [GEO_W-1:0] ox, oy, sw_g, sh_g;
  logic signed [GEO_W-1:0] cx0, cx1, cy0, cy1;
  logic [GEO_W-1:0]   w_clip, h_clip;
  logic               vis;

  assign fw   = clamp_dim(cfg.frame_width);
  assign fh   = clamp_dim(cfg.frame_height);
  assign sw   = clamp_dim(cfg.screen_width);
  assign sh   = clamp_dim(cfg.screen_height);
  assign prod = (2 * DIM_W)'(fw) * (2 * DIM_W)'(fh);

  // a column past a narrowed frame takes the whole run and then wraps
  assign head_room    = fw - col;
  assign head_over    = (col >= fw);
  assign head_fit     = (COUNT_W'(head_room) > left);
  assign head_wrap    = head_over || !head_fit;
  assign head_a       = (head_over || head_fit) ? left : COUNT_W'(head_room);
  assign head_col_sum = col + head_a[DIM_W-1:0];
  assign cnt_clamp    = (TOTAL_W'(count_r) > rem_px) ? rem_px[COUNT_W-1:0] : count_r;

  assign dividend = left;
  assign divisor  = fw;

  assign ox   = {{(GEO_W-CFG_W){cfg.origin_x[CFG_W-1]}}, cfg.origin_x};
  assign oy   = {{(GEO_W-CFG_W){cfg.origin_y[CFG_W-1]}}, cfg.origin_y};
  assign sw_g = {{(GEO_W-DIM_W){1'b0}}, sw};
  assign sh_g = {{(GEO_W-DIM_W){1'b0}}, sh};

  // clip to the screen
  assign cx0    = gx0[GEO_W-1] ? '0 : gx0;
  assign cy0    = gy0[GEO_W-1] ? '0 : gy0;
  assign cx1    = (gx1 > sw_g) ? sw_g : gx1;
  assign cy1    = (gy1 > sh_g) ? sh_g : gy1;
  assign vis    = (cx1 > cx0) && (cy1 > cy0);
  assign w_clip = cx1 - cx0;
  assign h_clip = cy1 - cy0;

  always_comb begin
    res                = '0;
    res.last           = rect_last;
    res.frame_complete = rect_last && comp;
    if (!null_res && vis) begin
      res.fill_x     = cx0[POS_W-1:0];
      res.fill_y     = cy0[POS_W-1:0];
      res.fill_w     = w_clip[DIM_W-1:0];
      res.fill_h     = h_clip[DIM_W-1:0];
      res.color      = color_r;
      res.fill_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    run_pop    = 1'b0;
    res_push   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!run_empty) begin
          run_pop    = 1'b1;
          state_next = ST_CLASS;
        end
      end
      ST_CLASS: begin
        state_next = (zero_r || pd >= total) ? ST_PUSH : ST_CLAMP;
      end
      ST_CLAMP: begin
        state_next = ST_HEAD;
      end
      ST_HEAD: begin
        state_next = (col != '0) ? ST_GEOM : ST_MID_CHECK;
      end
      ST_MID_CHECK: begin
        if (COUNT_W'(fw) <= left) begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end else begin
          state_next = ST_TAIL;
        end
      end
      ST_DIV_WAIT: begin
        if (div_status.done) begin
          state_next = ST_GEOM;
        end
      end
      ST_TAIL: begin
        state_next = (left != '0) ? ST_GEOM : ST_IDLE;
      end
      ST_GEOM: begin
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ret_state;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pd  <= '0;
      col <= '0;
      row <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!run_empty && run.frame_start) begin
            pd  <= '0;
            col <= '0;
            row <= '0;
          end
        end
        ST_CLAMP: begin
          pd <= pd + TOTAL_W'(cnt_clamp);
        end
        ST_HEAD: begin
          if (col != '0) begin
            if (head_wrap) begin
              col <= '0;
              row <= row + 1'b1;
            end else begin
              col <= head_col_sum;
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_status.done) begin
            row <= row + quotient[DIM_W-1:0];
          end
        end
        ST_TAIL: begin
          if (left != '0) begin
            col <= left[DIM_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!run_empty) begin
          count_r <= run.count;
          color_r <= run.color;
          zero_r  <= run.zero_run;
          lof_r   <= run.last_of_frame;
          total   <= prod[TOTAL_W-1:0];
        end
      end
      ST_CLASS: begin
        rem_px    <= total - pd;
        null_res  <= zero_r || (pd >= total);
        comp      <= lof_r && (pd == total);
        rect_last <= 1'b1;
        ret_state <= ST_IDLE;
      end
      ST_CLAMP: begin
        left <= cnt_clamp;
        comp <= lof_r && (TOTAL_W'(cnt_clamp) == rem_px);
      end
      ST_HEAD: begin
        if (col != '0) begin
          rect_col  <= col;
          rect_row  <= row;
          rect_w    <= head_a;
          rect_h    <= DIM_W'(1);
          rect_last <= (left == head_a);
          left      <= left - head_a;
          ret_state <= ST_MID_CHECK;
        end
      end
      ST_DIV_WAIT: begin
        if (div_status.done) begin
          rect_col  <= '0;
          rect_row  <= row;
          rect_w    <= COUNT_W'(fw);
          rect_h    <= quotient[DIM_W-1:0];
          rect_last <= (remainder == '0);
          left      <= COUNT_W'(remainder);
          ret_state <= ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (left != '0) begin
          rect_col  <= '0;
          rect_row  <= row;
          rect_w    <= left;
          rect_h    <= DIM_W'(1);
          rect_last <= 1'b1;
          ret_state <= ST_IDLE;
        end
      end
      ST_GEOM: begin
        gx0 <= ox + $signed({{(GEO_W-DIM_W){1'b0}}, rect_col});
        gy0 <= oy + $signed({{(GEO_W-DIM_W){1'b0}}, rect_row});
        gx1 <= ox + $signed({{(GEO_W-DIM_W){1'b0}}, rect_col})
                  + $signed({{(GEO_W-COUNT_W){1'b0}}, rect_w});
        gy1 <= oy + $signed({{(GEO_W-DIM_W){1'b0}}, rect_row})
                  + $signed({{(GEO_W-DIM_W){1'b0}}, rect_h});
      end
      default: ;
    endcase
  end

endmodule

### sv/rrfr_out_queue.sv
// ----------------------------------------------------------------------------
// rrfr_out_queue
// Small result queue between the rasterizer back end and the fill consumer.
// ----------------------------------------------------------------------------
module rrfr_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rrfr_pkg::result_t data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rrfr_pkg::result_t head
);
  import rrfr_pkg::*;

  localparam int PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(OQ_DEPTH + 1);

  result_t          slots [OQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(OQ_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= data;
    end
  end

endmodule
